// ===== rtl/core/ilp_pkg.sv =====
// Package for the integer literal parser: codes, character constants and helper functions.
package ilp_pkg;

   localparam int CHAR_W  = 8;
   localparam int ACCUM_W = 128;
   localparam int HALF_W  = 64;
   localparam int WIDE_W  = ACCUM_W + 4;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X    = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_O    = 8'h6F;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_O    = 8'h4F;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_B    = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_B    = 8'h42;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_I    = 8'h69;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_U    = 8'h75;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_S    = 8'h73;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_E    = 8'h65;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE        = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_TWO        = 8'h32;
   localparam logic [CHAR_W-1:0] CHAR_THREE      = 8'h33;
   localparam logic [CHAR_W-1:0] CHAR_FOUR       = 8'h34;
   localparam logic [CHAR_W-1:0] CHAR_SIX        = 8'h36;
   localparam logic [CHAR_W-1:0] CHAR_SEVEN      = 8'h37;
   localparam logic [CHAR_W-1:0] CHAR_EIGHT      = 8'h38;
   localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;

   localparam logic [1:0] POS_LAST = 2'd3;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef enum logic [9:0] {
      SFX_NONE    = 10'b00_0000_0001,
      SFX_LEAD    = 10'b00_0000_0010,
      SFX_ONE     = 10'b00_0000_0100,
      SFX_THREE   = 10'b00_0000_1000,
      SFX_SIX     = 10'b00_0001_0000,
      SFX_S       = 10'b00_0010_0000,
      SFX_ONE_TWO = 10'b00_0100_0000,
      SFX_SI      = 10'b00_1000_0000,
      SFX_SIZ     = 10'b01_0000_0000,
      SFX_DONE    = 10'b10_0000_0000
   } sfx_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] character;
      logic              is_last;
   } beat_type;

   function automatic digit_type digit_of(logic [CHAR_W-1:0] c, radix_type radix);
      digit_type d;
      logic      is_dec;
      d.valid = 1'b0;
      d.value = '0;
      is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (is_dec) begin
         d.value = DIGIT_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d.value = DIGIT_W'(c - CHAR_LOWER_A + 8'd10);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d.value = DIGIT_W'(c - CHAR_UPPER_A + 8'd10);
      end
      case (radix)
         RADIX_HEX: d.valid = is_dec || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                              (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
         RADIX_OCT: d.valid = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
         RADIX_BIN: d.valid = (c == CHAR_ZERO) || (c == CHAR_ONE);
         default:   d.valid = is_dec;
      endcase
      return d;
   endfunction

   // Mismatch returns SFX_NONE.
   function automatic sfx_type suffix_next(sfx_type phase, logic [CHAR_W-1:0] c);
      sfx_type n;
      n = SFX_NONE;
      case (phase)
         SFX_LEAD: begin
            if (c == CHAR_EIGHT)        n = SFX_DONE;
            else if (c == CHAR_ONE)     n = SFX_ONE;
            else if (c == CHAR_THREE)   n = SFX_THREE;
            else if (c == CHAR_SIX)     n = SFX_SIX;
            else if (c == CHAR_LOWER_S) n = SFX_S;
         end
         SFX_ONE: begin
            if (c == CHAR_SIX)      n = SFX_DONE;
            else if (c == CHAR_TWO) n = SFX_ONE_TWO;
         end
         SFX_ONE_TWO: if (c == CHAR_EIGHT)   n = SFX_DONE;
         SFX_THREE:   if (c == CHAR_TWO)     n = SFX_DONE;
         SFX_SIX:     if (c == CHAR_FOUR)    n = SFX_DONE;
         SFX_S:       if (c == CHAR_LOWER_I) n = SFX_SI;
         SFX_SI:      if (c == CHAR_LOWER_Z) n = SFX_SIZ;
         SFX_SIZ:     if (c == CHAR_LOWER_E) n = SFX_DONE;
         default:     n = SFX_NONE;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/int_literal_parser.sv =====
// Top level of the integer literal parser: lexer state, step logic and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_character[7:0], req_is_last
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_ok, rsp_value_low/high[63:0]
//
// One character beat per cycle while req_stall is low; a lexeme's result is loaded
// into the result register as its last beat leaves the input register.
// The per-character step is one 132-bit shift-add between the input register and
// the lexer state registers.
// Synchronous reset clears the lexer state and both valid flags.
// A stalled result holds; only a last beat waits behind it, other beats keep flowing.
module int_literal_parser
   import ilp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_character,
   input  logic              req_is_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_ok,
   output logic [HALF_W-1:0] rsp_value_low,
   output logic [HALF_W-1:0] rsp_value_high
);

   beat_type beat;
   logic     advance;

   logic [ACCUM_W-1:0] accum_ff, accum_in;
   radix_type          radix_ff, radix_in;
   logic [1:0]         pos_ff, pos_in;
   logic               seen_ff, seen_in;
   logic               failed_ff, failed_in;
   sfx_type            sfx_ff, sfx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, ok_in;
   logic [ACCUM_W-1:0] rsp_value_ff;

   digit_type          digit;
   logic [ACCUM_W-1:0] mac_sum;
   logic               mac_ovf;
   sfx_type            sfx_step;
   logic [CHAR_W-1:0]  c;
   logic               is_prefix;

   ilp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_is_last   (req_is_last),
      .advance       (advance),
      .req_stall     (req_stall),
      .beat          (beat)
   );

   assign c     = beat.character;
   assign digit = digit_of(c, radix_ff);

   ilp_mul_add u_mul_add (
      .accum    (accum_ff),
      .radix    (radix_ff),
      .digit    (digit.value),
      .sum      (mac_sum),
      .overflow (mac_ovf)
   );

   assign sfx_step  = suffix_next(sfx_ff, c);
   assign is_prefix = (pos_ff == 2'd1) && (radix_ff == RADIX_DEC) && seen_ff &&
                      (accum_ff == '0) &&
                      ((c == CHAR_LOWER_X) || (c == CHAR_UPPER_X) ||
                       (c == CHAR_LOWER_O) || (c == CHAR_UPPER_O) ||
                       (c == CHAR_LOWER_B) || (c == CHAR_UPPER_B));

   // Hold only a last beat while the previous result is stalled.
   assign advance = beat.valid && !(beat.is_last && rsp_valid_ff && rsp_stall);

   logic [ACCUM_W-1:0] acc_n;
   radix_type          radix_n;
   logic               seen_n, failed_n;
   sfx_type            sfx_n;

   always_comb begin
      acc_n    = accum_ff;
      radix_n  = radix_ff;
      seen_n   = seen_ff;
      failed_n = failed_ff;
      sfx_n    = sfx_ff;
      if (!failed_ff) begin
         if (sfx_ff != SFX_NONE) begin
            if (sfx_step == SFX_NONE) failed_n = 1'b1;
            else                      sfx_n    = sfx_step;
         end else if (pos_ff == 2'd0 && c == CHAR_MINUS) begin
            failed_n = 1'b1;
         end else if (c == CHAR_LOWER_I || c == CHAR_LOWER_U) begin
            if (pos_ff == 2'd0) failed_n = 1'b1;
            else                sfx_n    = SFX_LEAD;
         end else if (is_prefix) begin
            if (c == CHAR_LOWER_X || c == CHAR_UPPER_X)      radix_n = RADIX_HEX;
            else if (c == CHAR_LOWER_O || c == CHAR_UPPER_O) radix_n = RADIX_OCT;
            else                                             radix_n = RADIX_BIN;
            seen_n = 1'b0;
         end else if (c != CHAR_UNDERSCORE) begin
            if (!digit.valid || mac_ovf) begin
               failed_n = 1'b1;
            end else begin
               acc_n  = mac_sum;
               seen_n = 1'b1;
            end
         end
      end
      ok_in = !failed_n && seen_n && (sfx_n == SFX_NONE || sfx_n == SFX_DONE);
   end

   always_comb begin
      accum_in  = accum_ff;
      radix_in  = radix_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      sfx_in    = sfx_ff;
      if (advance) begin
         if (beat.is_last) begin
            // Drop back to the idle lexer state for the next lexeme.
            accum_in  = '0;
            radix_in  = RADIX_DEC;
            pos_in    = 2'd0;
            seen_in   = 1'b0;
            failed_in = 1'b0;
            sfx_in    = SFX_NONE;
         end else begin
            accum_in  = acc_n;
            radix_in  = radix_n;
            pos_in    = (pos_ff == POS_LAST) ? pos_ff : pos_ff + 2'd1;
            seen_in   = seen_n;
            failed_in = failed_n;
            sfx_in    = sfx_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         radix_ff  <= RADIX_DEC;
         pos_ff    <= 2'd0;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
         sfx_ff    <= SFX_NONE;
      end else begin
         accum_ff  <= accum_in;
         radix_ff  <= radix_in;
         pos_ff    <= pos_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
         sfx_ff    <= sfx_in;
      end
   end

   logic rsp_load;
   assign rsp_load     = advance && beat.is_last;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff    <= ok_in;
         rsp_value_ff <= ok_in ? acc_n : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_value_low  = rsp_value_ff[HALF_W-1:0];
   assign rsp_value_high = rsp_value_ff[ACCUM_W-1:HALF_W];

endmodule

// ===== rtl/core/ilp_in_reg.sv =====
// Input register stage: captures one character beat from the request channel.
module ilp_in_reg
   import ilp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [CHAR_W-1:0] req_character,
   input  logic              req_is_last,
   input  logic              advance,
   output logic              req_stall,
   output beat_type          beat
);

   logic              valid_ff;
   logic              valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic              load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= req_character;
         last_ff <= req_is_last;
      end
   end

   assign beat.valid     = valid_ff;
   assign beat.character = char_ff;
   assign beat.is_last   = last_ff;

endmodule

// ===== rtl/core/ilp_mul_add.sv =====
// Shift-add accumulator step: accum * radix + digit with overflow detect.
module ilp_mul_add
   import ilp_pkg::*;
(
   input  logic [ACCUM_W-1:0] accum,
   input  radix_type          radix,
   input  logic [DIGIT_W-1:0] digit,
   output logic [ACCUM_W-1:0] sum,
   output logic               overflow
);

   logic [WIDE_W-1:0] wide;
   logic [WIDE_W-1:0] scaled;

   assign wide = {4'b0000, accum};

   always_comb begin
      case (radix)
         RADIX_HEX: scaled = wide << 4;
         RADIX_OCT: scaled = wide << 3;
         RADIX_BIN: scaled = wide << 1;
         default:   scaled = (wide << 3) + (wide << 1);
      endcase
   end

   logic [WIDE_W-1:0] total;
   assign total    = scaled + {{(WIDE_W-DIGIT_W){1'b0}}, digit};
   assign sum      = total[ACCUM_W-1:0];
   assign overflow = |total[WIDE_W-1:ACCUM_W];

endmodule

// ===== rtl/core/ilp_checker.sv =====
// Port-level checker for the integer literal parser, bound to the top level.
module ilp_checker
   import ilp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_ok,
   input logic [HALF_W-1:0] rsp_value_low,
   input logic [HALF_W-1:0] rsp_value_high
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_value_low) && $stable(rsp_value_high))
      else $error("stalled result beat changed");

   // A failed lexeme reports a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value_low == '0 && rsp_value_high == '0)
      else $error("failed result carries a nonzero value");

   // With no result pending, the request side never stalls.
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty result register");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind int_literal_parser ilp_checker u_ilp_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for int_literal_parser: directed and random lexemes checked against a local predictor.
module tb_top
   import ilp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_CHARS = 1180;
   localparam int QUIET_AFTER  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam logic [4:0] NO_DIGIT = 5'h1F;

   typedef struct packed {
      logic              ok;
      logic [HALF_W-1:0] low;
      logic [HALF_W-1:0] high;
   } literal_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [CHAR_W-1:0] req_character = '0;
   logic              req_is_last   = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_ok;
   logic [HALF_W-1:0] rsp_value_low;
   logic [HALF_W-1:0] rsp_value_high;

   // lexer state as the block should hold it
   logic [ACCUM_W-1:0] acc;
   radix_type          radix;
   logic [1:0]         pos;
   logic               seen_digit;
   logic               lex_failed;
   sfx_type            sfx_phase;

   literal_type       pending_literals[$];
   logic [CHAR_W-1:0] lexeme[$];

   bit idle_on      = 1'b1;
   int gap_pct      = 15;
   int stall_pct    = 15;
   int stall_left   = 0;
   int cycles       = 0;
   int chars_sent   = 0;
   int lexemes_sent = 0;
   int results_seen = 0;
   int ok_results   = 0;
   int mismatches   = 0;
   int unexpected   = 0;

   int_literal_parser DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_literals.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Result side back-pressure in bursts.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end
   end

   always @(posedge clock) begin
      literal_type got;
      literal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_ok, rsp_value_low, rsp_value_high};
         results_seen++;
         if (pending_literals.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= MAX_REPORTS)
               $display("unexpected result: ok=%0b value=%h_%h", got.ok, got.high, got.low);
         end else begin
            want = pending_literals.pop_front();
            if (want.ok) ok_results++;
            if (got.ok !== want.ok || got.low !== want.low || got.high !== want.high) begin
               mismatches++;
               if (mismatches + unexpected <= MAX_REPORTS)
                  $display("mismatch on result %0d: expected ok=%0b value=%h_%h, %s",
                           results_seen, want.ok, want.high, want.low,
                           $sformatf("got ok=%0b value=%h_%h", got.ok, got.high, got.low));
            end
         end
      end
   end

   function automatic void restart_lexeme();
      acc        = '0;
      radix      = RADIX_DEC;
      pos        = 2'd0;
      seen_digit = 1'b0;
      lex_failed = 1'b0;
      sfx_phase  = SFX_NONE;
   endfunction

   function automatic int base_of(radix_type r);
      case (r)
         RADIX_HEX: return 16;
         RADIX_OCT: return 8;
         RADIX_BIN: return 2;
         default:   return 10;
      endcase
   endfunction

   // Decimal means the character is no prefix letter.
   function automatic radix_type prefix_radix(logic [CHAR_W-1:0] c);
      if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) return RADIX_HEX;
      if (c == CHAR_LOWER_O || c == CHAR_UPPER_O) return RADIX_OCT;
      if (c == CHAR_LOWER_B || c == CHAR_UPPER_B) return RADIX_BIN;
      return RADIX_DEC;
   endfunction

   function automatic logic [4:0] digit_value(logic [CHAR_W-1:0] c, int base);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE)
         d = 5'(c - CHAR_ZERO);
      else if (base > 10 && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
         d = 5'(c - CHAR_LOWER_A) + 5'd10;
      else if (base > 10 && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
         d = 5'(c - CHAR_UPPER_A) + 5'd10;
      return (int'(d) < base) ? d : NO_DIGIT;
   endfunction

   function automatic sfx_type next_phase(sfx_type p, logic [CHAR_W-1:0] c);
      case (p)
         SFX_LEAD: begin
            if (c == CHAR_EIGHT)   return SFX_DONE;
            if (c == CHAR_ONE)     return SFX_ONE;
            if (c == CHAR_THREE)   return SFX_THREE;
            if (c == CHAR_SIX)     return SFX_SIX;
            if (c == CHAR_LOWER_S) return SFX_S;
         end
         SFX_ONE: begin
            if (c == CHAR_SIX) return SFX_DONE;
            if (c == CHAR_TWO) return SFX_ONE_TWO;
         end
         SFX_ONE_TWO: if (c == CHAR_EIGHT)   return SFX_DONE;
         SFX_THREE:   if (c == CHAR_TWO)     return SFX_DONE;
         SFX_SIX:     if (c == CHAR_FOUR)    return SFX_DONE;
         SFX_S:       if (c == CHAR_LOWER_I) return SFX_SI;
         SFX_SI:      if (c == CHAR_LOWER_Z) return SFX_SIZ;
         SFX_SIZ:     if (c == CHAR_LOWER_E) return SFX_DONE;
         default:     return SFX_NONE;
      endcase
      return SFX_NONE;
   endfunction

   // Advance the lexer by one accepted character; queue the literal on the last one.
   task automatic lex_char(input logic [CHAR_W-1:0] c, input logic last);
      sfx_type            nxt;
      logic [4:0]         d;
      logic [ACCUM_W+4:0] wide;
      literal_type        res;
      if (!lex_failed) begin
         if (sfx_phase != SFX_NONE) begin
            nxt = next_phase(sfx_phase, c);
            if (nxt == SFX_NONE) lex_failed = 1'b1;
            else sfx_phase = nxt;
         end else if (pos == 2'd0 && c == CHAR_MINUS) begin
            lex_failed = 1'b1;
         end else if (c == CHAR_LOWER_I || c == CHAR_LOWER_U) begin
            // a suffix needs a core in front of it
            if (pos == 2'd0) lex_failed = 1'b1;
            else sfx_phase = SFX_LEAD;
         end else if (pos == 2'd1 && radix == RADIX_DEC && seen_digit && acc == '0 &&
                      prefix_radix(c) != RADIX_DEC) begin
            radix      = prefix_radix(c);
            seen_digit = 1'b0;
         end else if (c != CHAR_UNDERSCORE) begin
            d    = digit_value(c, base_of(radix));
            wide = {5'd0, acc} * (ACCUM_W + 5)'(base_of(radix)) + (ACCUM_W + 5)'(d);
            if (d == NO_DIGIT || wide[ACCUM_W+4:ACCUM_W] != '0) begin
               lex_failed = 1'b1;
            end else begin
               acc        = wide[ACCUM_W-1:0];
               seen_digit = 1'b1;
            end
         end
      end
      if (pos != POS_LAST) pos = pos + 2'd1;
      if (last) begin
         res.ok   = !lex_failed && seen_digit &&
                    (sfx_phase == SFX_NONE || sfx_phase == SFX_DONE);
         res.low  = res.ok ? acc[HALF_W-1:0] : '0;
         res.high = res.ok ? acc[ACCUM_W-1:HALF_W] : '0;
         pending_literals.push_back(res);
         restart_lexeme();
      end
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      req_is_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_char(c, last);
      chars_sent++;
   endtask

   task automatic send_lexeme();
      for (int i = 0; i < lexeme.size(); i++)
         send_char(lexeme[i], i == lexeme.size() - 1);
      lexemes_sent++;
   endtask

   task automatic put(input string s);
      for (int i = 0; i < s.len(); i++) lexeme.push_back(s[i]);
   endtask

   task automatic send_str(input string s);
      lexeme.delete();
      put(s);
      send_lexeme();
   endtask

   task automatic put_suffix();
      lexeme.push_back($urandom_range(0, 1) ? CHAR_LOWER_I : CHAR_LOWER_U);
      case ($urandom_range(0, 5))
         0:       put("8");
         1:       put("16");
         2:       put("32");
         3:       put("64");
         4:       put("128");
         default: put("size");
      endcase
   endtask

   // Literal with random radix, digits, separators and an optional suffix; the longest may overflow.
   task automatic build_literal();
      radix_type r;
      string     digits;
      int        n;
      lexeme.delete();
      r = radix_type'($urandom_range(0, 3));
      case (r)
         RADIX_HEX: begin digits = "0123456789abcdefABCDEF"; n = 32; end
         RADIX_OCT: begin digits = "01234567";               n = 43; end
         RADIX_BIN: begin digits = "01";                     n = 128; end
         default:   begin digits = "0123456789";             n = 39; end
      endcase
      // mostly short; now and then right around the full 128-bit width
      if ($urandom_range(0, 11) == 0) n = n - 1 + $urandom_range(0, 2);
      else n = $urandom_range(1, 6);
      if (r != RADIX_DEC) begin
         lexeme.push_back(CHAR_ZERO);
         case (r)
            RADIX_HEX: lexeme.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            RADIX_OCT: lexeme.push_back($urandom_range(0, 1) ? CHAR_LOWER_O : CHAR_UPPER_O);
            default:   lexeme.push_back($urandom_range(0, 1) ? CHAR_LOWER_B : CHAR_UPPER_B);
         endcase
      end
      repeat (n) begin
         if ($urandom_range(0, 5) == 0) lexeme.push_back(CHAR_UNDERSCORE);
         lexeme.push_back(digits[$urandom_range(0, digits.len() - 1)]);
      end
      if ($urandom_range(0, 2) == 0) put_suffix();
   endtask

   task automatic test_prefixes();
      send_str("0");
      send_str("0x1F");
      send_str("0XaB");
      send_str("0o17");
      send_str("0O7");
      send_str("0b101");
      send_str("0B1");
      send_str("0x");
      send_str("0b2");
      send_str("0o8");
      send_str("1x");
      send_str("00x1");
      send_str("0xfg");
   endtask

   task automatic test_suffixes();
      send_str("7i128");
      send_str("5usize");
      send_str("9u8");
      send_str("3i16");
      send_str("1u32");
      send_str("2i64");
      send_str("u8");
      send_str("0x_u8");
      send_str("4u8_");
      send_str("6i12");
      send_str("8isiz");
      send_str("1u7");
   endtask

   task automatic test_signs_and_separators();
      send_str("-1");
      send_str("_");
      send_str("1_000");
      send_str("__5__");
      send_str("1-");
      send_str("9z");
      lexeme.delete();
      lexeme.push_back(8'h35);
      lexeme.push_back(8'h80);
      send_lexeme();
      lexeme.delete();
      lexeme.push_back(8'h00);
      send_lexeme();
      lexeme.delete();
      lexeme.push_back(8'hFF);
      send_lexeme();
   endtask

   task automatic test_extremes();
      send_str("340282366920938463463374607431768211455");
      send_str("340282366920938463463374607431768211456");
      send_str("0xffffffffffffffffffffffffffffffffu128");
      send_str("0x100000000000000000000000000000000");
   endtask

   task automatic test_random_literals();
      int start;
      start = chars_sent;
      while (chars_sent - start < RANDOM_CHARS) begin
         // quiet tail: no gaps, no stalls
         if (chars_sent - start > QUIET_AFTER) idle_on = 1'b0;
         if (lexemes_sent % 16 == 0) begin
            gap_pct   = 15 * $urandom_range(0, 2);
            stall_pct = 15 * $urandom_range(0, 2);
         end
         case ($urandom_range(0, 9))
            7, 8: begin
               build_literal();
               case ($urandom_range(0, 4))
                  0: lexeme[$urandom_range(0, lexeme.size() - 1)] =
                        CHAR_W'($urandom_range(0, 255));
                  1: lexeme.push_front(CHAR_MINUS);
                  2: if (lexeme.size() > 1) lexeme.delete(lexeme.size() - 1);
                  3: begin
                     string junk;
                     junk = "iu_xob-8Z";
                     lexeme.push_back(junk[$urandom_range(0, junk.len() - 1)]);
                  end
                  default: begin
                     lexeme.delete();
                     put_suffix();
                  end
               endcase
            end
            9: begin
               lexeme.delete();
               repeat ($urandom_range(1, 6)) lexeme.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            default: build_literal();
         endcase
         send_lexeme();
      end
   endtask

   initial begin
      restart_lexeme();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_prefixes();
      test_suffixes();
      test_signs_and_separators();
      test_extremes();
      test_random_literals();
      req_valid <= 1'b0;
      while (pending_literals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d characters in %0d lexemes, %0d results checked, %0d valid literals",
               chars_sent, lexemes_sent, results_seen, ok_results);
      $display("summary: %0d mismatches, %0d results with nothing expected, %0d left over",
               mismatches, unexpected, pending_literals.size());
      if (mismatches == 0 && unexpected == 0 && pending_literals.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ilp_pkg.sv
rtl/core/ilp_in_reg.sv
rtl/core/ilp_mul_add.sv
rtl/core/int_literal_parser.sv
rtl/core/ilp_checker.sv
tb/sv/tb_top.sv
